@@ rtl/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Flags and precomputed squared terms that travel down the pipe with the color.
  typedef struct packed {
    logic       sat_full;
    logic       sat_zero;
    logic       val_full;
    logic [7:0] desat;
    logic [7:0] vsq;
  } ctl_t;

  typedef struct packed {
    rgb_t color;
    ctl_t ctl;
  } pipe_t;

  localparam logic [7:0] ONE_THIRD  = 8'd85;
  localparam logic [7:0] TWO_THIRDS = 8'd170;
  localparam logic [7:0] FULL       = 8'd255;

  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = a * b;
    return p[15:8];
  endfunction

  function automatic logic [7:0] scale8_round(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = scale8(a, b);
    if (a != 8'd0 && b != 8'd0) begin
      r = r + 8'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/hsv2rgb_hue.sv @@
`timescale 1ns / 1ps

module hsv2rgb_hue (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  hsv2rgb_pkg::hsv_t   hsv,
  output logic                valid_out,
  output hsv2rgb_pkg::pipe_t  pipe_out
);
  import hsv2rgb_pkg::*;

  typedef enum logic [2:0] {
    SEC_RED_ORANGE,
    SEC_ORANGE_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_AQUA,
    SEC_AQUA_BLUE,
    SEC_BLUE_PURPLE,
    SEC_PURPLE_PINK,
    SEC_PINK_RED
  } sec_t;

  sec_t       sec;
  logic [7:0] ramp;
  logic [7:0] third;
  logic [7:0] twoth;
  logic [7:0] sat_inv;
  pipe_t      pipe_next;

  assign sec     = sec_t'(hsv.hue[7:5]);
  assign ramp    = {hsv.hue[4:0], 3'b000};
  assign third   = scale8(ramp, ONE_THIRD);
  assign twoth   = scale8(ramp, TWO_THIRDS);
  assign sat_inv = FULL - hsv.saturation;

  always_comb begin
    pipe_next = '0;
    case (sec)
      SEC_RED_ORANGE: begin
        pipe_next.color = '{FULL - third, third, 8'd0};
      end
      SEC_ORANGE_YELLOW: begin
        pipe_next.color = '{8'd171, ONE_THIRD + third, 8'd0};
      end
      SEC_YELLOW_GREEN: begin
        pipe_next.color = '{8'd171 - twoth, TWO_THIRDS + third, 8'd0};
      end
      SEC_GREEN_AQUA: begin
        pipe_next.color = '{8'd0, FULL - third, third};
      end
      SEC_AQUA_BLUE: begin
        pipe_next.color = '{8'd0, 8'd171 - twoth, ONE_THIRD + twoth};
      end
      SEC_BLUE_PURPLE: begin
        pipe_next.color = '{third, 8'd0, FULL - third};
      end
      SEC_PURPLE_PINK: begin
        pipe_next.color = '{ONE_THIRD + third, 8'd0, 8'd171 - third};
      end
      default: begin
        pipe_next.color = '{TWO_THIRDS + third, 8'd0, ONE_THIRD - third};
      end
    endcase
    pipe_next.ctl.sat_full = (hsv.saturation == FULL);
    pipe_next.ctl.sat_zero = (hsv.saturation == 8'd0);
    pipe_next.ctl.val_full = (hsv.brightness == FULL);
    pipe_next.ctl.desat    = scale8_round(sat_inv, sat_inv);
    pipe_next.ctl.vsq      = scale8_round(hsv.brightness, hsv.brightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    pipe_out <= pipe_next;
  end

endmodule

@@ rtl/hsv2rgb_sat.sv @@
`timescale 1ns / 1ps

module hsv2rgb_sat (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  hsv2rgb_pkg::pipe_t  pipe_in,
  output logic                valid_out,
  output hsv2rgb_pkg::pipe_t  pipe_out
);
  import hsv2rgb_pkg::*;

  logic [7:0] keep;
  pipe_t      pipe_next;

  assign keep = FULL - pipe_in.ctl.desat;

  function automatic logic [7:0] desat_ch(input logic [7:0] c, input logic [7:0] k,
                                          input logic [7:0] d);
    logic [7:0] s;
    s = (c != 8'd0) ? scale8(c, k) + 8'd1 : 8'd0;
    return s + d;
  endfunction

  always_comb begin
    pipe_next = pipe_in;
    if (pipe_in.ctl.sat_zero) begin
      pipe_next.color = '{FULL, FULL, FULL};
    end else if (!pipe_in.ctl.sat_full) begin
      pipe_next.color.red   = desat_ch(pipe_in.color.red, keep, pipe_in.ctl.desat);
      pipe_next.color.green = desat_ch(pipe_in.color.green, keep, pipe_in.ctl.desat);
      pipe_next.color.blue  = desat_ch(pipe_in.color.blue, keep, pipe_in.ctl.desat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    pipe_out <= pipe_next;
  end

endmodule

@@ rtl/hsv2rgb_val.sv @@
`timescale 1ns / 1ps

module hsv2rgb_val (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  hsv2rgb_pkg::pipe_t  pipe_in,
  output logic                valid_out,
  output hsv2rgb_pkg::rgb_t   rgb_out
);
  import hsv2rgb_pkg::*;

  rgb_t rgb_next;

  function automatic logic [7:0] dim_ch(input logic [7:0] c, input logic [7:0] v);
    logic [7:0] r;
    r = 8'd0;
    if (v != 8'd0 && c != 8'd0) begin
      r = scale8(c, v) + 8'd1;
    end
    return r;
  endfunction

  always_comb begin
    rgb_next = pipe_in.color;
    if (!pipe_in.ctl.val_full) begin
      rgb_next.red   = dim_ch(pipe_in.color.red, pipe_in.ctl.vsq);
      rgb_next.green = dim_ch(pipe_in.color.green, pipe_in.ctl.vsq);
      rgb_next.blue  = dim_ch(pipe_in.color.blue, pipe_in.ctl.vsq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rgb_out <= rgb_next;
  end

endmodule

@@ rtl/hsv_to_rgb_rainbow.sv @@
// A beat taken with start passes the hue map, saturation and value registers in turn, then shows on rgb with done.
// Throughput: one beat per cycle while busy is low; three register stages (hue map, saturation, value).
// The receiver cannot stall, so done pulses for exactly one cycle per beat.
// Reset (rst, synchronous, active high) clears the stage valid bits; busy is high during reset.
`timescale 1ns / 1ps

module hsv_to_rgb_rainbow (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  hsv2rgb_pkg::hsv_t  hsv,
  output logic               done,
  output hsv2rgb_pkg::rgb_t  rgb
);
  import hsv2rgb_pkg::*;

  logic  hue_valid;
  logic  sat_valid;
  pipe_t hue_pipe;
  pipe_t sat_pipe;

  assign busy = rst;

  hsv2rgb_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start && !busy),
    .hsv       (hsv),
    .valid_out (hue_valid),
    .pipe_out  (hue_pipe)
  );

  hsv2rgb_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (hue_valid),
    .pipe_in   (hue_pipe),
    .valid_out (sat_valid),
    .pipe_out  (sat_pipe)
  );

  hsv2rgb_val u_val (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sat_valid),
    .pipe_in   (sat_pipe),
    .valid_out (done),
    .rgb_out   (rgb)
  );

endmodule

@@ rtl/hsv2rgb_checker.sv @@
`timescale 1ns / 1ps

module hsv2rgb_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input hsv2rgb_pkg::hsv_t  hsv,
  input logic               done,
  input hsv2rgb_pkg::rgb_t  rgb
);
  import hsv2rgb_pkg::*;

  // Every accepted beat comes out as a done strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("accepted beat did not produce a result after three cycles");

  // No result appears without a matching accepted beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result strobe without a matching accepted beat");

  // Zero saturation at full brightness is pure white.
  a_white: assert property (@(posedge clk) disable iff (rst)
    start && !busy && hsv.saturation == 8'd0 && hsv.brightness == FULL
    |-> ##3 (rgb.red == FULL && rgb.green == FULL && rgb.blue == FULL))
    else $error("zero saturation at full value did not give white");

  // Zero brightness is black whatever the hue and saturation.
  a_black: assert property (@(posedge clk) disable iff (rst)
    start && !busy && hsv.brightness == 8'd0
    |-> ##3 (rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0))
    else $error("zero value did not give black");

endmodule

bind hsv_to_rgb_rainbow hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ dv/hsv_to_rgb_rainbow_tb.sv @@
`timescale 1ns / 1ps

module hsv_to_rgb_rainbow_tb;
  import hsv2rgb_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  hsv_t hsv = '0;
  logic done;
  rgb_t rgb;

  hsv_t pending_hsv[$];
  rgb_t expected_rgb[$];
  int gap_left = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  int fail_count = 0;

  hsv_to_rgb_rainbow u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsv   (hsv),
    .done  (done),
    .rgb   (rgb)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] frac8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = a * b;
    return prod[15:8];
  endfunction

  function automatic logic [7:0] frac8_round(input logic [7:0] a, input logic [7:0] b);
    return frac8(a, b) + ((a != 8'd0 && b != 8'd0) ? 8'd1 : 8'd0);
  endfunction

  // Rainbow hue map, then the blend toward white, then the scale toward black.
  function automatic rgb_t rainbow_rgb(input hsv_t px);
    logic [7:0] ramp, third, twoth, desat, keep, vsq;
    logic [7:0] chan[3];
    rgb_t res;
    ramp  = {px.hue[4:0], 3'b000};
    third = frac8(ramp, ONE_THIRD);
    twoth = frac8(ramp, TWO_THIRDS);
    case (px.hue[7:5])
      3'd0: begin
        chan[0] = FULL - third;   chan[1] = third;          chan[2] = 8'd0;
      end
      3'd1: begin
        chan[0] = 8'd171;         chan[1] = 8'd85 + third;  chan[2] = 8'd0;
      end
      3'd2: begin
        chan[0] = 8'd171 - twoth; chan[1] = 8'd170 + third; chan[2] = 8'd0;
      end
      3'd3: begin
        chan[0] = 8'd0;           chan[1] = FULL - third;   chan[2] = third;
      end
      3'd4: begin
        chan[0] = 8'd0;           chan[1] = 8'd171 - twoth; chan[2] = 8'd85 + twoth;
      end
      3'd5: begin
        chan[0] = third;          chan[1] = 8'd0;           chan[2] = FULL - third;
      end
      3'd6: begin
        chan[0] = 8'd85 + third;  chan[1] = 8'd0;           chan[2] = 8'd171 - third;
      end
      default: begin
        chan[0] = 8'd170 + third; chan[1] = 8'd0;           chan[2] = 8'd85 - third;
      end
    endcase
    if (px.saturation == 8'd0) begin
      chan[0] = FULL;
      chan[1] = FULL;
      chan[2] = FULL;
    end else if (px.saturation != FULL) begin
      desat = frac8_round(FULL - px.saturation, FULL - px.saturation);
      keep  = FULL - desat;
      for (int k = 0; k < 3; k++) begin
        if (chan[k] != 8'd0) begin
          chan[k] = frac8(chan[k], keep) + 8'd1;
        end
        chan[k] = chan[k] + desat;
      end
    end
    if (px.brightness != FULL) begin
      vsq = frac8_round(px.brightness, px.brightness);
      for (int k = 0; k < 3; k++) begin
        if (vsq == 8'd0) begin
          chan[k] = 8'd0;
        end else if (chan[k] != 8'd0) begin
          chan[k] = frac8(chan[k], vsq) + 8'd1;
        end
      end
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  // Mostly uniform bytes, with a fair share of the values at the edges of the map.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[10] = '{8'd0, 8'd1, 8'd2, 8'd31, 8'd32, 8'd127, 8'd128,
                                8'd224, 8'd254, 8'd255};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 9)];
    end
    return 8'($urandom);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  task automatic queue_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    hsv_t px;
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    pending_hsv.push_back(px);
  endtask

  // Driver: one beat is taken at each edge where start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rgb.push_back(rainbow_rgb(hsv));
      end
      if (start && busy) begin
        // Hold the beat until the block takes it.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_hsv.size() > 0) begin
        start <= 1'b1;
        hsv <= pending_hsv.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) :
                      $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    rgb_t want;
    if (!rst && done) begin
      if (expected_rgb.size() == 0) begin
        note_failure($sformatf("result with nothing pending: rgb=%0d/%0d/%0d",
                               rgb.red, rgb.green, rgb.blue));
      end else begin
        want = expected_rgb.pop_front();
        if (rgb.red !== want.red || rgb.green !== want.green || rgb.blue !== want.blue) begin
          note_failure($sformatf("rgb mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.red, want.green, want.blue,
                                 rgb.red, rgb.green, rgb.blue));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // Every hue section at both ends of its ramp, full color and full brightness.
    for (int sec = 0; sec < 8; sec++) begin
      queue_pixel(8'(sec * 32), FULL, FULL);
      queue_pixel(8'(sec * 32 + 31), FULL, FULL);
    end
    queue_pixel(8'd100, 8'd0, FULL);     // white
    queue_pixel(8'd40, 8'd1, FULL);      // nearly white
    queue_pixel(8'd200, 8'd254, 8'd200);
    queue_pixel(8'd10, 8'd128, 8'd0);    // black
    queue_pixel(8'd150, FULL, 8'd1);     // dimmest non-black
    queue_pixel(8'd5, FULL, 8'd254);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd77, 8'd128, 8'd128);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_pixel(pick_byte(), pick_byte(), pick_byte());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_hsv.size() > 0 || start || expected_rgb.size() > 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (expected_rgb.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_rgb.size()));
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
